// ----- src/mlt_pkg.sv -----
// shared types and constants for the linked multimap table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mlt_pkg;
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 6;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_MOSTF  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic [IDX_W-1:0]    wr_addr;
        logic                kv_we;
        logic                link_we;
        logic [2*DATA_W-1:0] kv_wdata;
        logic [LINK_W-1:0]   link_wdata;
    } mem_req_t;
endpackage
`default_nettype wire

// ----- src/linked_multimap_table_core.sv -----
// top level of the linked multimap table: entry memories, sequencer, result register
// depends on mlt_pkg, mlt_ram, mlt_ctrl
`timescale 1ns / 1ps
`default_nettype none
// multimap of up to 32 key/value pairs kept as a linked list in two small rams.
// one request is taken at a time; s_tready is low from acceptance until its last
// result has been loaded into the result register. insert reads the free chain
// head, then writes the new entry at the list head; remove and lookup read and
// check one entry at a time, and most-frequent walks the whole list once for every
// entry, through the single read port of the entry memories. lookup gives one result
// per matching pair with m_tlast on the final one. no clearing pass after reset.
module linked_multimap_table_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // command[1:0], key[33:2], value[65:34], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // status[1:0], value_out[33:2], entry_count[39:34]
    output logic        m_tlast
);
    import mlt_pkg::*;

    result_t               emit;
    mem_req_t              mreq;
    logic [2*DATA_W-1:0]   kv_q;
    logic [LINK_W-1:0]     link_q;
    logic                  out_free;
    logic                  m_valid_reg;
    logic [39:0]           m_data_reg;
    logic                  m_last_reg;

    // result register frees up as soon as its result is taken
    assign out_free = !m_valid_reg || m_tready;

    mlt_ctrl u_ctrl (
        .clk      (aclk),
        .rst_n    (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tdata[1:0]),
        .in_key   (s_tdata[33:2]),
        .in_val   (s_tdata[65:34]),
        .out_free (out_free),
        .emit     (emit),
        .mreq     (mreq),
        .kv_q     (kv_q),
        .link_q   (link_q)
    );

    // key and value of each entry
    mlt_ram #(.WIDTH(2*DATA_W), .DEPTH(CAPACITY)) u_kv_ram (
        .clk   (aclk),
        .we    (mreq.kv_we),
        .waddr (mreq.wr_addr),
        .wdata (mreq.kv_wdata),
        .re    (mreq.rd_en),
        .raddr (mreq.rd_addr),
        .rdata (kv_q)
    );

    // next links of the used list and the free chain
    mlt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (aclk),
        .we    (mreq.link_we),
        .waddr (mreq.wr_addr),
        .wdata (mreq.link_wdata),
        .re    (mreq.rd_en),
        .raddr (mreq.rd_addr),
        .rdata (link_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_data_reg <= {emit.count, emit.value, emit.status};
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
endmodule
`default_nettype wire

// ----- src/mlt_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- src/mlt_ctrl.sv -----
// sequencer that walks the linked entries with one shared compare unit
// depends on mlt_pkg
`timescale 1ns / 1ps
`default_nettype none
module mlt_ctrl (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [1:0]                   in_cmd,
    input  wire  [mlt_pkg::DATA_W-1:0]   in_key,
    input  wire  [mlt_pkg::DATA_W-1:0]   in_val,
    input  wire                          out_free,
    output mlt_pkg::result_t             emit,
    output mlt_pkg::mem_req_t            mreq,
    input  wire  [2*mlt_pkg::DATA_W-1:0] kv_q,
    input  wire  [mlt_pkg::LINK_W-1:0]   link_q
);
    import mlt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_INS     = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_CHK     = 4'd4;
    localparam logic [3:0] S_LKEND   = 4'd5;
    localparam logic [3:0] S_REMFREE = 4'd6;
    localparam logic [3:0] S_MFORD   = 4'd7;
    localparam logic [3:0] S_MFOGET  = 4'd8;
    localparam logic [3:0] S_MFIRD   = 4'd9;
    localparam logic [3:0] S_MFICHK  = 4'd10;
    localparam logic [3:0] S_MFEMIT  = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [DATA_W-1:0]   key_reg, key_next, val_reg, val_next;
    logic [LINK_W-1:0]   cur_reg, cur_next, prev_reg, prev_next;
    logic [LINK_W-1:0]   head_reg, head_next, free_reg, free_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                pend_v_reg, pend_v_next;
    logic [DATA_W-1:0]   pend_reg, pend_next, cand_reg, cand_next, best_reg, best_next;
    logic [LINK_W-1:0]   onext_reg, onext_next, ic_reg, ic_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next, bestn_reg, bestn_next;
    logic [CAPACITY-1:0] lvalid_reg, lvalid_next;
    logic [IDX_W-1:0]    raddr_q_reg;

    logic [LINK_W-1:0] link_rd;
    logic [DATA_W-1:0] cmp_ref;
    logic              key_eq, val_eq;
    logic [CNT_W-1:0]  cnt_inc;

    // unwritten links read as the reset free chain
    assign link_rd = lvalid_reg[raddr_q_reg] ? link_q
                   : LINK_W'({1'b0, raddr_q_reg}) + LINK_W'(1);
    // shared compare unit
    assign cmp_ref = (cmd_reg == CMD_MOSTF) ? cand_reg : val_reg;
    assign key_eq  = (kv_q[2*DATA_W-1:DATA_W] == key_reg);
    assign val_eq  = (kv_q[DATA_W-1:0] == cmp_ref);
    assign cnt_inc = cnt_reg + CNT_W'(val_eq);

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        cand_next   = cand_reg;
        best_next   = best_reg;
        onext_next  = onext_reg;
        ic_next     = ic_reg;
        cnt_next    = cnt_reg;
        bestn_next  = bestn_reg;
        lvalid_next = lvalid_reg;
        mreq        = '0;
        emit        = '0;
        emit.last   = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    key_next   = in_key;
                    val_next   = in_val;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (free_reg == NIL_LINK) begin
                        if (out_free) begin
                            emit.valid  = 1'b1;
                            emit.status = ST_FULL;
                            state_next  = S_IDLE;
                        end
                    end else begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = free_reg[IDX_W-1:0];
                        state_next   = S_INS;
                    end
                end else if (head_reg == NIL_LINK) begin
                    if (out_free) begin
                        emit.valid  = 1'b1;
                        emit.status = ST_NOTFOUND;
                        state_next  = S_IDLE;
                    end
                end else begin
                    cur_next    = head_reg;
                    prev_next   = NIL_LINK;
                    pend_v_next = 1'b0;
                    bestn_next  = '0;
                    best_next   = '0;
                    state_next  = (cmd_reg == CMD_MOSTF) ? S_MFORD : S_RD;
                end
            end
            S_INS: begin
                if (out_free) begin
                    free_next       = link_rd;
                    mreq.wr_addr    = free_reg[IDX_W-1:0];
                    mreq.kv_we      = 1'b1;
                    mreq.kv_wdata   = {key_reg, val_reg};
                    mreq.link_we    = 1'b1;
                    mreq.link_wdata = head_reg;
                    lvalid_next[free_reg[IDX_W-1:0]] = 1'b1;
                    head_next       = free_reg;
                    count_next      = count_reg + CNT_W'(1);
                    emit.valid      = 1'b1;
                    emit.status     = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_RD: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = cur_reg[IDX_W-1:0];
                state_next   = S_CHK;
            end
            S_CHK: begin
                if (cmd_reg == CMD_REMOVE) begin
                    if (key_eq && val_eq) begin
                        // unlink from the list
                        if (prev_reg == NIL_LINK) begin
                            head_next = link_rd;
                        end else begin
                            mreq.wr_addr    = prev_reg[IDX_W-1:0];
                            mreq.link_we    = 1'b1;
                            mreq.link_wdata = link_rd;
                            lvalid_next[prev_reg[IDX_W-1:0]] = 1'b1;
                        end
                        state_next = S_REMFREE;
                    end else if (link_rd == NIL_LINK) begin
                        if (out_free) begin
                            emit.valid  = 1'b1;
                            emit.status = ST_NOTFOUND;
                            state_next  = S_IDLE;
                        end
                    end else begin
                        prev_next  = cur_reg;
                        cur_next   = link_rd;
                        state_next = S_RD;
                    end
                end else if (!(key_eq && pend_v_reg && !out_free)) begin
                    // lookup: a match is held back until the next one shows up or the list ends
                    if (key_eq) begin
                        if (pend_v_reg) begin
                            emit.valid  = 1'b1;
                            emit.status = ST_OK;
                            emit.value  = pend_reg;
                            emit.last   = 1'b0;
                        end
                        pend_v_next = 1'b1;
                        pend_next   = kv_q[DATA_W-1:0];
                    end
                    cur_next   = link_rd;
                    state_next = (link_rd == NIL_LINK) ? S_LKEND : S_RD;
                end
            end
            S_LKEND: begin
                if (out_free) begin
                    emit.valid  = 1'b1;
                    emit.status = pend_v_reg ? ST_OK : ST_NOTFOUND;
                    emit.value  = pend_v_reg ? pend_reg : '0;
                    state_next  = S_IDLE;
                end
            end
            S_REMFREE: begin
                if (out_free) begin
                    mreq.wr_addr    = cur_reg[IDX_W-1:0];
                    mreq.link_we    = 1'b1;
                    mreq.link_wdata = free_reg;
                    lvalid_next[cur_reg[IDX_W-1:0]] = 1'b1;
                    free_next       = cur_reg;
                    count_next      = count_reg - CNT_W'(1);
                    emit.valid      = 1'b1;
                    emit.status     = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_MFORD: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = cur_reg[IDX_W-1:0];
                state_next   = S_MFOGET;
            end
            S_MFOGET: begin
                cand_next  = kv_q[DATA_W-1:0];
                onext_next = link_rd;
                ic_next    = head_reg;
                cnt_next   = '0;
                state_next = S_MFIRD;
            end
            S_MFIRD: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = ic_reg[IDX_W-1:0];
                state_next   = S_MFICHK;
            end
            S_MFICHK: begin
                cnt_next = cnt_inc;
                ic_next  = link_rd;
                if (link_rd == NIL_LINK) begin
                    // strict compare keeps the first value met on a tie
                    if (cnt_inc > bestn_reg) begin
                        bestn_next = cnt_inc;
                        best_next  = cand_reg;
                    end
                    cur_next   = onext_reg;
                    state_next = (onext_reg == NIL_LINK) ? S_MFEMIT : S_MFORD;
                end else begin
                    state_next = S_MFIRD;
                end
            end
            S_MFEMIT: begin
                if (out_free) begin
                    emit.valid  = 1'b1;
                    emit.status = ST_OK;
                    emit.value  = best_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        emit.count = count_next;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            head_reg   <= NIL_LINK;
            free_reg   <= '0;
            count_reg  <= '0;
            lvalid_reg <= '0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
            lvalid_reg <= lvalid_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        pend_v_reg  <= pend_v_next;
        pend_reg    <= pend_next;
        cand_reg    <= cand_next;
        best_reg    <= best_next;
        onext_reg   <= onext_next;
        ic_reg      <= ic_next;
        cnt_reg     <= cnt_next;
        bestn_reg   <= bestn_next;
        if (mreq.rd_en) begin
            raddr_q_reg <= mreq.rd_addr;
        end
    end
endmodule
`default_nettype wire

// ----- src/mlt_checker.sv -----
// port level checks for the linked multimap table and their bind
// depends on mlt_pkg, linked_multimap_table_core
`timescale 1ns / 1ps
`default_nettype none
module mlt_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast
);
    import mlt_pkg::*;

    // a stalled result stays up
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:34] <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // full is only reported when every entry is used
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[39:34] == CNT_W'(CAPACITY) && m_tlast)
        else $error("full status with free entries");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_NOTFOUND || m_tdata[1:0] == ST_FULL)
        |-> m_tdata[33:2] == 32'd0 && m_tlast)
        else $error("failed request carries a value");
endmodule

bind linked_multimap_table_core mlt_checker u_mlt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- test/linked_multimap_table_core_chk.sv -----
// result checker for the linked multimap table: predicts every result from accepted requests
// depends on mlt_pkg
`timescale 1ns / 1ps
`default_nettype none
module linked_multimap_table_core_chk (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [71:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,
    input  wire         m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    import mlt_pkg::*;

    typedef struct {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              last;
    } table_result_t;

    // shadow of the table state
    logic [DATA_W-1:0] keys_q [CAPACITY];
    logic [DATA_W-1:0] vals_q [CAPACITY];
    int                nxt_q  [CAPACITY];
    int                prv_q  [CAPACITY];
    int                head_q, free_q, npairs;
    table_result_t     expected_results[$];

    function automatic void push_result(logic [1:0] st, logic [DATA_W-1:0] v, logic lst);
        table_result_t r;
        r.status = st;
        r.value  = v;
        r.count  = CNT_W'(npairs);
        r.last   = lst;
        expected_results = {expected_results, r};
    endfunction

    function automatic int count_matching_values(logic [DATA_W-1:0] v);
        int c, n;
        c = head_q;
        n = 0;
        for (int s = 0; s < CAPACITY && c < CAPACITY; s++) begin
            if (vals_q[c] == v) n++;
            c = nxt_q[c];
        end
        return n;
    endfunction

    function automatic void apply_request(logic [1:0] cmd, logic [DATA_W-1:0] k,
                                          logic [DATA_W-1:0] v);
        int c, p, n, hits, best_n;
        logic [DATA_W-1:0] best;
        logic done;
        case (cmd)
            CMD_INSERT: begin
                if (free_q >= CAPACITY) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    c = free_q;
                    free_q = nxt_q[c];
                    if (free_q < CAPACITY) prv_q[free_q] = CAPACITY;
                    keys_q[c] = k;
                    vals_q[c] = v;
                    prv_q[c] = CAPACITY;
                    nxt_q[c] = head_q;
                    if (head_q < CAPACITY) prv_q[head_q] = c;
                    head_q = c;
                    npairs++;
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_REMOVE: begin
                c = head_q;
                done = 1'b0;
                for (int s = 0; s < CAPACITY && c < CAPACITY && !done; s++) begin
                    if (keys_q[c] == k && vals_q[c] == v) begin
                        p = prv_q[c];
                        n = nxt_q[c];
                        if (p < CAPACITY) nxt_q[p] = n; else head_q = n;
                        if (n < CAPACITY) prv_q[n] = p;
                        nxt_q[c] = free_q;
                        prv_q[c] = CAPACITY;
                        if (free_q < CAPACITY) prv_q[free_q] = c;
                        free_q = c;
                        npairs--;
                        done = 1'b1;
                    end else begin
                        c = nxt_q[c];
                    end
                end
                push_result(done ? ST_OK : ST_NOTFOUND, '0, 1'b1);
            end
            CMD_LOOKUP: begin
                c = head_q;
                hits = 0;
                for (int s = 0; s < CAPACITY && c < CAPACITY; s++) begin
                    if (keys_q[c] == k) begin
                        push_result(ST_OK, vals_q[c], 1'b0);
                        hits++;
                    end
                    c = nxt_q[c];
                end
                if (hits == 0) push_result(ST_NOTFOUND, '0, 1'b1);
                else expected_results[$].last = 1'b1;
            end
            default: begin
                if (head_q >= CAPACITY) begin
                    push_result(ST_NOTFOUND, '0, 1'b1);
                end else begin
                    c = head_q;
                    best = '0;
                    best_n = 0;
                    for (int s = 0; s < CAPACITY && c < CAPACITY; s++) begin
                        n = count_matching_values(vals_q[c]);
                        if (n > best_n) begin
                            best_n = n;
                            best = vals_q[c];
                        end
                        c = nxt_q[c];
                    end
                    push_result(ST_OK, best, 1'b1);
                end
            end
        endcase
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        table_result_t e;
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++) begin
                keys_q[i] <= '0;
                vals_q[i] <= '0;
                nxt_q[i] <= i + 1;
                prv_q[i] <= (i == 0) ? CAPACITY : i - 1;
            end
            head_q <= CAPACITY;
            free_q <= 0;
            npairs <= 0;
            fail_count <= 0;
            results_seen <= 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: status %0d value %h count %0d last %0b",
                                 m_tdata[1:0], m_tdata[33:2], m_tdata[39:34], m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[1:0] !== e.status || m_tdata[33:2] !== e.value ||
                        m_tdata[39:34] !== e.count || m_tlast !== e.last) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp st %0d val %h cnt %0d last %0b, ",
                                      "got st %0d val %h cnt %0d last %0b"},
                                     e.status, e.value, e.count, e.last, m_tdata[1:0],
                                     m_tdata[33:2], m_tdata[39:34], m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // request predicted after the result pop, so a same-cycle pair stays ordered
            if (s_tvalid && s_tready)
                apply_request(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]);
        end
    end
endmodule
`default_nettype wire

// ----- test/linked_multimap_table_core_tb.sv -----
// stimulus and verdict for the linked multimap table core
// depends on mlt_pkg, linked_multimap_table_core, linked_multimap_table_core_chk
`timescale 1ns / 1ps
`default_nettype none
module linked_multimap_table_core_tb;
    import mlt_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count, pending, results_seen;
    int          requests_sent = 0;
    logic        long_hold = 1'b0;
    logic        stim_done = 1'b0;

    // small pools so that keys and values repeat and lookups hit
    logic [31:0] key_pool [8];
    logic [31:0] val_pool [8];

    initial begin
        forever #5 aclk = ~aclk;
    end

    linked_multimap_table_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    linked_multimap_table_core_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // offer one request and hold it until the handshake
    task automatic send_request(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, v, k, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic random_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick(logic [31:0] pool [8]);
        return ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
    endfunction

    // receiver: random stall pattern, plus one long hold-off counted here
    initial begin
        int phase;
        int hold_cycles;
        logic held;
        phase = 0;
        held = 1'b0;
        while (1) begin
            @(posedge aclk);
            phase++;
            if (long_hold && !held) begin
                m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 200) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                held = 1'b1;
                m_tready <= 1'b1;
            end
            else if ((phase / 40) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial begin
        logic [1:0] cmd;
        int burst;
        for (int i = 0; i < 8; i++) begin
            key_pool[i] = $urandom();
            val_pool[i] = $urandom();
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        val_pool[0] = 32'hffff_ffff;
        val_pool[1] = 32'h0000_0000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table cases, extremes, duplicates, tie on most-frequent
        send_request(CMD_MOSTF, 32'h0, 32'h0);
        send_request(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(CMD_REMOVE, 32'h0, 32'h0);
        send_request(CMD_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'h7fff_ffff, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_MOSTF, 32'h0, 32'h0);
        send_request(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(CMD_REMOVE, 32'h8000_0000, 32'h1234_5678);
        send_request(CMD_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
        send_request(CMD_MOSTF, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h8000_0000, 32'hffff_ffff);
        // fill to capacity, one more insert hits the full case; receiver held off
        long_hold <= 1'b1;
        for (int i = 0; i < CAPACITY; i++)
            send_request(CMD_INSERT, key_pool[i % 2], val_pool[i % 3]);
        send_request(CMD_INSERT, 32'h1, 32'h1);
        send_request(CMD_LOOKUP, key_pool[0], 32'h0);
        send_request(CMD_MOSTF, 32'h0, 32'h0);
        for (int i = 0; i < CAPACITY; i++)
            send_request(CMD_REMOVE, key_pool[i % 2], val_pool[i % 3]);

        // random: mostly inserts and removes over small pools, bursts with gaps
        burst = 0;
        for (int i = 0; i < 190; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cmd = CMD_INSERT;
                4, 5, 6:    cmd = CMD_REMOVE;
                7, 8:       cmd = CMD_LOOKUP;
                default:    cmd = CMD_MOSTF;
            endcase
            send_request(cmd, pick(key_pool), pick(val_pool));
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                random_gap();
            end else begin
                burst--;
            end
        end
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge aclk);
        repeat (2200) @(posedge aclk);
        $display("sent %0d requests (directed empty, full and tie cases, random mix)",
                 requests_sent);
        $display("checked %0d results", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("linked_multimap_table_core_tb OK");
        else
            $display("linked_multimap_table_core_tb NOT OK");
        $finish;
    end

    // generous run limit
    initial begin
        #50ms;
        $display("timeout");
        $display("linked_multimap_table_core_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
